// ----- rtl/dense_prim_spanning_forest_macros.svh -----
// Assertion macros used by the checker.
`ifndef DENSE_PRIM_SPANNING_FOREST_MACROS_SVH
`define DENSE_PRIM_SPANNING_FOREST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DPSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dpsf_pkg.sv -----
package dpsf_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_BITS = $clog2(MAX_NODES);
  localparam int CNT_BITS  = NODE_BITS + 1;
  localparam int COST_BITS = 16;
  localparam int ADDR_BITS = 2 * NODE_BITS;

  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [COST_BITS-1:0] cost_t;

  localparam cost_t COST_INF = '1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef struct packed {
    logic en;
    logic first;
  } relax_ctl_t;

  typedef struct packed {
    logic  pending;
    node_t pick_k;
    node_t pick_v;
  } relax_stat_t;

endpackage

// ----- rtl/dpsf_ram.sv -----
module dpsf_ram #(
  parameter int WIDTH     = 16,
  parameter int ADDR_BITS = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dpsf_relax.sv -----
module dpsf_relax import dpsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  relax_ctl_t  ctl,
  input  node_t       v,
  input  node_t       k,
  input  cost_t       arc,
  input  cost_t       best,
  output cost_t       nb,
  output logic        upd,
  output relax_stat_t stat
);

  logic  en_q;
  logic  first_q;
  cost_t nb_q;
  node_t v_q;
  node_t k_q;
  cost_t min_cost;
  node_t pick_k;
  node_t pick_v;

  assign upd = arc < best;
  assign nb  = upd ? arc : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_q <= 1'b0;
    end else begin
      en_q <= ctl.en;
    end
    first_q <= ctl.first;
    nb_q    <= nb;
    v_q     <= v;
    k_q     <= k;
    if (en_q && (first_q || nb_q < min_cost)) begin
      min_cost <= nb_q;
      pick_k   <= k_q;
      pick_v   <= v_q;
    end
  end

  assign stat.pending = en_q;
  assign stat.pick_k  = pick_k;
  assign stat.pick_v  = pick_v;

endmodule

// ----- rtl/dense_prim_spanning_forest.sv -----
// Write beat: the arc cost lands in the matrix memory.
// Start beat: a set-up pass over the n vertices, then for each settled vertex m < n-1 a round
// through the one relax/compare unit, with an extra swap step when the pick is swapped.
// Then n result beats on consecutive cycles, vertex order; the receiver cannot stall.
// busy rises the cycle after the start beat and drops as the last result beat appears.
// Reset clears control and sets node_count to 64; the matrix memory is not cleared.
module dense_prim_spanning_forest import dpsf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  logic  action,
  input  node_t row,
  input  node_t col,
  input  cost_t arc_cost,
  input  logic  node_count_we,
  input  cnt_t  node_count,
  output logic  strobe,
  output node_t vertex,
  output node_t parent,
  output cost_t tree_cost,
  output logic  last
);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ROUND, S_SCAN, S_DRAIN, S_SWAP, S_SWAP2, S_OUT
  } state_t;

  state_t state;
  cnt_t   node_count_reg;
  cnt_t   n;
  node_t  n_last;
  node_t  m;
  node_t  m_next;
  node_t  idx;
  node_t  u;
  node_t  first_v;

  logic   s1_valid;
  logic   s1_first;
  node_t  s1_k;
  logic   s2_valid;
  logic   s2_first;
  node_t  s2_k;
  node_t  s2_v;

  logic                 q_we;
  node_t                q_waddr;
  node_t                q_wdata;
  node_t                q_rd;
  logic                 best_we;
  node_t                best_waddr;
  cost_t                best_wdata;
  node_t                best_raddr;
  cost_t                best_rd;
  logic                 par_we;
  node_t                par_wdata;
  logic                 cost_we;
  cost_t                cost_rd;

  relax_ctl_t  rctl;
  relax_stat_t rstat;
  cost_t       nb;
  logic        upd;

  assign busy   = state != S_IDLE;
  assign n_last = node_t'(n - cnt_t'(1));
  assign m_next = m + node_t'(1);

  always_comb begin
    q_we    = 1'b0;
    q_waddr = idx;
    q_wdata = idx;
    case (state)
      S_INIT: begin
        q_we = 1'b1;
      end
      S_SWAP: begin
        q_we    = rstat.pick_k != m_next;
        q_waddr = m_next;
        q_wdata = rstat.pick_v;
      end
      S_SWAP2: begin
        q_we    = 1'b1;
        q_waddr = rstat.pick_k;
        q_wdata = first_v;
      end
      default: begin
        q_we = 1'b0;
      end
    endcase
  end

  assign best_we    = (state == S_INIT) || s2_valid;
  assign best_waddr = (state == S_INIT) ? idx : s2_v;
  assign best_wdata = (state == S_INIT) ? COST_INF : nb;
  assign best_raddr = (state == S_OUT) ? idx : q_rd;
  assign par_we     = (state == S_INIT) || (s2_valid && upd);
  assign par_wdata  = (state == S_INIT) ? idx : u;
  assign cost_we    = start && !busy && (action == ACT_WRITE)
                      && (CNT_BITS'(row) < CNT_BITS'(MAX_NODES))
                      && (CNT_BITS'(col) < CNT_BITS'(MAX_NODES));

  dpsf_ram #(.WIDTH(NODE_BITS), .ADDR_BITS(NODE_BITS)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(idx), .rdata(q_rd)
  );

  dpsf_ram #(.WIDTH(COST_BITS), .ADDR_BITS(NODE_BITS)) u_best (
    .clk(clk), .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
    .raddr(best_raddr), .rdata(best_rd)
  );

  dpsf_ram #(.WIDTH(NODE_BITS), .ADDR_BITS(NODE_BITS)) u_parent (
    .clk(clk), .we(par_we), .waddr(best_waddr), .wdata(par_wdata),
    .raddr(idx), .rdata(parent)
  );

  dpsf_ram #(.WIDTH(COST_BITS), .ADDR_BITS(ADDR_BITS)) u_matrix (
    .clk(clk), .we(cost_we), .waddr({row, col}), .wdata(arc_cost),
    .raddr({q_rd, u}), .rdata(cost_rd)
  );

  assign rctl.en    = s2_valid;
  assign rctl.first = s2_first;

  dpsf_relax u_relax (
    .clk(clk), .rst(rst), .ctl(rctl), .v(s2_v), .k(s2_k),
    .arc(cost_rd), .best(best_rd), .nb(nb), .upd(upd), .stat(rstat)
  );

  assign tree_cost = best_rd;

  // relax pipeline: queue read, then matrix and best-cost read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= state == S_SCAN;
      s2_valid <= s1_valid;
    end
    s1_first <= idx == m_next;
    s1_k     <= idx;
    s2_first <= s1_first;
    s2_k     <= s1_k;
    s2_v     <= q_rd;
    if (s2_valid && s2_first) begin
      first_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      node_count_reg <= cnt_t'(MAX_NODES);
      strobe         <= 1'b0;
    end else begin
      strobe <= state == S_OUT;
      if (node_count_we) begin
        node_count_reg <= node_count;
      end
      case (state)
        S_IDLE: begin
          if (start && action == ACT_START) begin
            if (node_count_reg == '0) begin
              n <= cnt_t'(1);
            end else if (node_count_reg > cnt_t'(MAX_NODES)) begin
              n <= cnt_t'(MAX_NODES);
            end else begin
              n <= node_count_reg;
            end
            idx   <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (idx == n_last) begin
            m     <= '0;
            u     <= '0;
            state <= S_ROUND;
          end else begin
            idx <= idx + node_t'(1);
          end
        end
        S_ROUND: begin
          if (m == n_last) begin
            idx   <= '0;
            state <= S_OUT;
          end else begin
            idx   <= m_next;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == n_last) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + node_t'(1);
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !s2_valid && !rstat.pending) begin
            state <= S_SWAP;
          end
        end
        S_SWAP: begin
          if (rstat.pick_k != m_next) begin
            state <= S_SWAP2;
          end else begin
            m     <= m_next;
            u     <= rstat.pick_v;
            state <= S_ROUND;
          end
        end
        S_SWAP2: begin
          m     <= m_next;
          u     <= rstat.pick_v;
          state <= S_ROUND;
        end
        S_OUT: begin
          vertex <= idx;
          last   <= idx == n_last;
          if (idx == n_last) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + node_t'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/dpsf_checker.sv -----
`include "dense_prim_spanning_forest_macros.svh"

module dpsf_checker import dpsf_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  start,
  input logic  busy,
  input logic  action,
  input logic  strobe,
  input node_t vertex,
  input logic  last
);

  `DPSF_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy && action == ACT_START, busy,
    "start beat did not raise busy")
  `DPSF_ASSERT_NOW(a_mid_busy, clk, rst, strobe && !last, busy,
    "busy dropped before the last result beat")
  `DPSF_ASSERT_NEXT(a_burst, clk, rst, strobe && !last,
    strobe && (vertex == node_t'($past(vertex) + node_t'(1))),
    "result beats not consecutive in vertex order")
  `DPSF_ASSERT_NEXT(a_end, clk, rst, strobe && last, !strobe,
    "result beat after the last one")

endmodule

bind dense_prim_spanning_forest dpsf_checker u_dpsf_checker (.*);
